// ===== rtl/cfks_pkg.sv =====
// Shared constants, command types and rate tables for the four-state kinetic step.
package cfks_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ADDR_BITS = 8;
  localparam int TSIZE     = 1 << ADDR_BITS;
  localparam int OCC_W     = FRAC_BITS + 1;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE_K1    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_K2    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_GD1   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_GD2   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_GR    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_E12   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_E21   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_RATE = 4'd7;

  localparam logic [31:0] SCALE_RESET  = 32'd16777216;
  localparam logic [16:0] FILTER_RESET = 17'd5041;

  localparam longint Q30       = longint'(1) << 30;
  localparam longint HALF30    = longint'(1) << (29 - FRAC_BITS);
  localparam longint LN2_30    = 744261118;
  localparam longint C025_30   = 26843546;
  localparam longint C043_30   = 46170898;
  localparam longint KGR_30    = 22713857;
  localparam longint GR16      = 28481094;
  localparam longint E12D_30   = 11811160;
  localparam longint C1_30     = 5368709;
  localparam longint E21D_30   = 8589935;
  localparam longint C3_30     = 4294967;
  localparam longint GD2_30    = 1073742;
  localparam longint E1_16     = 55935;
  localparam longint E2_16     = 9175;
  localparam longint GAMMA_30  = 107374182;
  localparam longint FLUX_C4   = 1573;
  localparam longint GD2_BASE  = (GD2_30 + HALF30) >>> (30 - FRAC_BITS);

  localparam int TAB_SIG  = 0;
  localparam int TAB_GD1  = 1;
  localparam int TAB_GR   = 2;
  localparam int TAB_LOG2 = 3;

  typedef longint tab_t [0:TSIZE];

  typedef enum logic [4:0] {
    OP_FETCH, OP_FETCH2, OP_GD1B, OP_GRB, OP_LOG, OP_LNF, OP_E12B, OP_E21B,
    OP_GD1, OP_GR, OP_E12, OP_E21, OP_GD2, OP_LA, OP_T, OP_K1B, OP_K2B,
    OP_K1, OP_K2, OP_D1, OP_D2, OP_D3, OP_D4, OP_D5, OP_D6, OP_D7,
    OP_UPDATE, OP_COND
  } op_t;

  typedef struct packed {
    logic load;
    logic exec;
    op_t  op;
  } dp_cmd_t;

  // long division of nonnegative values by compare and subtract
  function automatic longint udiv(longint num, longint den);
    longint q;
    longint rem;
    q   = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem << 1) | ((num >>> b) & 1);
      if (rem >= den) begin
        rem = rem - den;
        q   = q | (longint'(1) << b);
      end
    end
    return q;
  endfunction

  function automatic longint exp30(longint y_in);
    longint y;
    longint n;
    longint r;
    longint term;
    longint sum;
    y    = y_in;
    term = Q30;
    sum  = Q30;
    if (y > 20 * Q30) y = 20 * Q30;
    if (y < -40 * Q30) y = -40 * Q30;
    if (y >= 0) n = y / LN2_30;
    else n = -((-y + LN2_30 - 1) / LN2_30);
    r = y - n * LN2_30;
    for (int k = 1; k <= 14; k++) begin
      term = udiv((term * r) >>> 30, longint'(k));
      sum  = sum + term;
    end
    if (n >= 0) return sum << n;
    return sum >>> (-n);
  endfunction

  function automatic longint log2_entry(int i);
    longint x;
    longint ip;
    longint fr;
    x  = Q30 + (longint'(i) << (30 - ADDR_BITS));
    ip = 0;
    fr = 0;
    if (x >= (longint'(1) << 31)) begin
      x  = x >>> 1;
      ip = 1;
    end
    for (int b = 1; b <= FRAC_BITS + 1; b++) begin
      x = (x * x) >>> 30;
      if (x >= (longint'(1) << 31)) begin
        x  = x >>> 1;
        fr = fr | (longint'(1) << (FRAC_BITS + 1 - b));
      end
    end
    return (ip << FRAC_BITS) + ((fr + 1) >>> 1);
  endfunction

  function automatic tab_t build_tab(int sel);
    tab_t   tab;
    longint x30;
    longint e;
    longint s30;
    longint vr;
    longint v30;
    longint t30;
    longint val;
    for (int i = 0; i <= TSIZE; i++) begin
      vr  = (longint'(i) << (16 - ADDR_BITS)) - 32768;
      v30 = vr * 4194304;
      case (sel)
        TAB_SIG: begin
          x30 = longint'(12000) * i * (longint'(1) << (22 - ADDR_BITS)) - 12 * Q30;
          e   = exp30(-2 * x30);
          s30 = udiv(longint'(1) << 60, Q30 + e);
          tab[i] = (s30 + HALF30) >>> (30 - FRAC_BITS);
        end
        TAB_GD1: begin
          e   = exp30(-(v30 + 20 * Q30) / 10);
          t30 = Q30 - udiv(longint'(1) << 61, e + Q30);
          val = C025_30 + ((C043_30 * t30) >>> 30);
          tab[i] = (val + HALF30) >>> (30 - FRAC_BITS);
        end
        TAB_GR: begin
          e = exp30(-((KGR_30 * vr) >>> 8));
          tab[i] = (e * GR16 + (longint'(1) << (45 - FRAC_BITS))) >>> (46 - FRAC_BITS);
        end
        default: tab[i] = log2_entry(i);
      endcase
    end
    return tab;
  endfunction

  localparam tab_t SIG_TAB  = build_tab(TAB_SIG);
  localparam tab_t GD1_TAB  = build_tab(TAB_GD1);
  localparam tab_t GR_TAB   = build_tab(TAB_GR);
  localparam tab_t LOG2_TAB = build_tab(TAB_LOG2);

  // log2 of the flux offset alone, the zero point of the log shape
  localparam int     C4_EXP  = 10;
  localparam longint C4_MN   = (FLUX_C4 - (longint'(1) << C4_EXP)) << (16 - C4_EXP);
  localparam int     C4_IDX  = int'(C4_MN >>> 8);
  localparam longint C4_FRAC = C4_MN & 255;
  localparam longint LOG2_ZERO = (longint'(C4_EXP) << FRAC_BITS) + LOG2_TAB[C4_IDX]
      + (((LOG2_TAB[C4_IDX + 1] - LOG2_TAB[C4_IDX]) * C4_FRAC) >>> 8);

endpackage

// ===== rtl/chr2_four_state_kinetic_step.sv =====
// Top level of the four-state kinetic step: sequencer plus datapath.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------
//   in       | in_valid / in_stall     | light_flux, membrane_mv
//   out      | out_valid / out_stall   | conductance
//   cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// An item is accepted in S_IDLE and then runs 28 sequencer steps, set by the
// single shared 34x34 multiplier that every rate and occupancy term goes through.
// The next item is accepted the cycle after the result is loaded, while that
// result may still wait on out_stall. A stalled output holds the final step.
// Reset loads the register defaults and the fully closed state; no clearing pass.
module chr2_four_state_kinetic_step (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [31:0]                     light_flux,
  input  logic signed [15:0]              membrane_mv,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [16:0]                     conductance,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cfks_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data
);
  import cfks_pkg::*;

  dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  cfks_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  cfks_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .light_flux  (light_flux),
    .membrane_mv (membrane_mv),
    .conductance (conductance)
  );

endmodule

// ===== rtl/cfks_ctrl.sv =====
// Sequencer that steps the datapath through one time step per item.
module cfks_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output cfks_pkg::dp_cmd_t cmd
);
  import cfks_pkg::*;

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t state;
  op_t    op;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  assign cmd.load = (state == S_IDLE) && in_valid;
  assign cmd.exec = (state == S_RUN) && ((op != OP_COND) || out_free);
  assign cmd.op   = op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_FETCH;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_RUN;
            op    <= OP_FETCH;
          end
        end
        S_RUN: begin
          if (op == OP_COND) begin
            if (out_free) begin
              out_valid <= 1'b1;
              state     <= S_IDLE;
              op        <= OP_FETCH;
            end
          end else begin
            op <= op_t'(5'(op) + 5'd1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/cfks_dp.sv =====
// Datapath: table fetch, one shared multiplier, rate and occupancy registers.
module cfks_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  cfks_pkg::dp_cmd_t               cmd,
  input  logic                            cfg_we,
  input  logic [cfks_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data,
  input  logic [31:0]                     light_flux,
  input  logic signed [15:0]              membrane_mv,
  output logic [16:0]                     conductance
);
  import cfks_pkg::*;

  logic [31:0] sc_k1, sc_k2, sc_gd1, sc_gd2, sc_gr, sc_e12, sc_e21;
  logic [16:0] lfr;

  logic [16:0] o1, o2, c1, c2, la;

  logic [31:0]        flux_q;
  logic [15:0]        vpos_q;
  logic [16:0]        s_q;
  logic signed [17:0] gd1_lo, gd1_d;
  logic [29:0]        gr_lo;
  logic signed [30:0] gr_d;
  logic [5:0]         le_q;
  logic [15:0]        mn_q;
  logic [16:0]        log_lo;
  logic signed [17:0] log_d;
  logic signed [18:0] gd1b;
  logic [29:0]        grb;
  logic [21:0]        lval, lnf;
  logic [16:0]        e12b, e21b;
  logic signed [25:0] gd1;
  logic [24:0]        gr, e12, e21, gd2, k1, k2;
  logic [31:0]        t_q, k1b, k2b;
  logic signed [25:0] d_q [7];

  logic signed [33:0] ma, mb;
  logic signed [67:0] prod, p8, p16, prod_r;
  logic [43:0]        prod_hi;
  logic [24:0]        rate_sat;
  logic [33:0]        e_sum;
  logic [8:0]         vi, mi, si;
  logic [32:0]        a33, norm;
  logic [5:0]         le;
  logic [15:0]        mn;
  logic signed [17:0] la_diff;
  logic [16:0]        fr;
  logic [18:0]        gd1_mag;
  logic signed [19:0] la_sum;
  logic signed [29:0] o1_sum, o2_sum, c2_sum, c1_sum;
  logic [16:0]        o1_n, o2_n, c2_n;
  logic [17:0]        cond_sum;

  function automatic logic [16:0] clamp01(logic signed [29:0] x);
    if (x < 0) return 17'd0;
    if (x > 30'sd65536) return 17'd65536;
    return x[16:0];
  endfunction

  function automatic logic signed [29:0] sx26(logic signed [25:0] x);
    return {{4{x[25]}}, x};
  endfunction

  // leading-one position and aligned mantissa of flux plus offset
  always_comb begin
    a33 = {1'b0, flux_q} + 33'(FLUX_C4);
    le  = 6'd0;
    for (int i = 0; i < 33; i++) begin
      if (a33[i]) le = 6'(i);
    end
    norm = a33 << (6'd32 - le);
    mn   = norm[31:16];
  end

  assign vi = {1'b0, vpos_q[15:8]};
  assign mi = {1'b0, mn_q[15:8]};
  assign si = {1'b0, flux_q[7:0]};

  assign la_diff = $signed({1'b0, s_q}) - $signed({1'b0, la});
  assign fr      = (lfr > 17'd65536) ? 17'd65536 : lfr;
  assign gd1_mag = gd1b[18] ? 19'(-gd1b) : gd1b;

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_GD1B: begin ma = {{16{gd1_d[17]}}, gd1_d}; mb = {26'd0, vpos_q[7:0]}; end
      OP_GRB:  begin ma = {{3{gr_d[30]}}, gr_d};    mb = {26'd0, vpos_q[7:0]}; end
      OP_LOG:  begin ma = {{16{log_d[17]}}, log_d}; mb = {26'd0, mn_q[7:0]};   end
      OP_LNF:  begin ma = {12'd0, lval};            mb = 34'(LN2_30);          end
      OP_E12B: begin ma = 34'(C1_30);               mb = {12'd0, lnf};         end
      OP_E21B: begin ma = 34'(C3_30);               mb = {12'd0, lnf};         end
      OP_GD1:  begin ma = {15'd0, gd1_mag};         mb = {2'b0, sc_gd1};       end
      OP_GR:   begin ma = {4'd0, grb};              mb = {2'b0, sc_gr};        end
      OP_E12:  begin ma = {17'd0, e12b};            mb = {2'b0, sc_e12};       end
      OP_E21:  begin ma = {17'd0, e21b};            mb = {2'b0, sc_e21};       end
      OP_GD2:  begin ma = 34'(GD2_BASE);            mb = {2'b0, sc_gd2};       end
      OP_LA:   begin ma = {{16{la_diff[17]}}, la_diff}; mb = {17'd0, fr};      end
      OP_T:    begin ma = {2'b0, flux_q};           mb = {17'd0, la};          end
      OP_K1B:  begin ma = {2'b0, t_q};              mb = 34'(E1_16);           end
      OP_K2B:  begin ma = {2'b0, t_q};              mb = 34'(E2_16);           end
      OP_K1:   begin ma = {2'b0, k1b};              mb = {2'b0, sc_k1};        end
      OP_K2:   begin ma = {2'b0, k2b};              mb = {2'b0, sc_k2};        end
      OP_D1:   begin ma = {9'd0, k1};               mb = {17'd0, c1};          end
      OP_D2:   begin ma = {{8{gd1[25]}}, gd1};      mb = {17'd0, o1};          end
      OP_D3:   begin ma = {9'd0, gr};               mb = {17'd0, c2};          end
      OP_D4:   begin ma = {9'd0, e21};              mb = {17'd0, o2};          end
      OP_D5:   begin ma = {9'd0, e12};              mb = {17'd0, o1};          end
      OP_D6:   begin ma = {9'd0, k2};               mb = {17'd0, c2};          end
      OP_D7:   begin ma = {9'd0, gd2};              mb = {17'd0, o2};          end
      OP_COND: begin ma = {17'd0, o2};              mb = 34'(GAMMA_30);        end
      default: begin ma = '0;                       mb = '0;                   end
    endcase
  end

  assign prod     = ma * mb;
  assign p8       = prod >>> 8;
  assign p16      = prod >>> 16;
  assign prod_r   = prod + (68'sd1 <<< 29);
  assign prod_hi  = prod[67:24];
  assign rate_sat = (prod_hi > 44'd16777216) ? 25'd16777216 : prod[48:24];
  assign e_sum    = prod[49:16] + 34'(HALF30)
                  + ((cmd.op == OP_E12B) ? 34'(E12D_30) : 34'(E21D_30));
  assign la_sum   = $signed({3'b0, la}) + p16[19:0];

  always_comb begin
    o1_sum = $signed({13'd0, o1}) + sx26(d_q[0]) + sx26(d_q[3]) - sx26(d_q[1]) - sx26(d_q[4]);
    o2_sum = $signed({13'd0, o2}) + sx26(d_q[5]) + sx26(d_q[4]) - sx26(d_q[6]) - sx26(d_q[3]);
    c2_sum = $signed({13'd0, c2}) + sx26(d_q[6]) - sx26(d_q[5]) - sx26(d_q[2]);
    o1_n   = clamp01(o1_sum);
    o2_n   = clamp01(o2_sum);
    c2_n   = clamp01(c2_sum);
    c1_sum = 30'sd65536 - $signed({13'd0, o1_n}) - $signed({13'd0, o2_n})
           - $signed({13'd0, c2_n});
  end

  assign cond_sum = {1'b0, o1} + prod_r[47:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_k1  <= SCALE_RESET;
      sc_k2  <= SCALE_RESET;
      sc_gd1 <= SCALE_RESET;
      sc_gd2 <= SCALE_RESET;
      sc_gr  <= SCALE_RESET;
      sc_e12 <= SCALE_RESET;
      sc_e21 <= SCALE_RESET;
      lfr    <= FILTER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE_K1:    sc_k1  <= cfg_data;
        REG_SCALE_K2:    sc_k2  <= cfg_data;
        REG_SCALE_GD1:   sc_gd1 <= cfg_data;
        REG_SCALE_GD2:   sc_gd2 <= cfg_data;
        REG_SCALE_GR:    sc_gr  <= cfg_data;
        REG_SCALE_E12:   sc_e12 <= cfg_data;
        REG_SCALE_E21:   sc_e21 <= cfg_data;
        REG_FILTER_RATE: lfr    <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o1 <= 17'd0;
      o2 <= 17'd0;
      c2 <= 17'd0;
      c1 <= 17'd65536;
      la <= 17'd0;
    end else if (cmd.exec) begin
      case (cmd.op)
        OP_LA:     la <= clamp01(30'(la_sum));
        OP_UPDATE: begin
          o1 <= o1_n;
          o2 <= o2_n;
          c2 <= c2_n;
          c1 <= clamp01(c1_sum);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      flux_q <= light_flux;
      vpos_q <= {~membrane_mv[15], membrane_mv[14:0]};
    end
    if (cmd.exec) begin
      case (cmd.op)
        OP_FETCH: begin
          s_q    <= (flux_q >= 32'd256) ? 17'(SIG_TAB[TSIZE]) : 17'(SIG_TAB[si]);
          gd1_lo <= 18'(GD1_TAB[vi]);
          gd1_d  <= 18'(GD1_TAB[vi + 9'd1] - GD1_TAB[vi]);
          gr_lo  <= 30'(GR_TAB[vi]);
          gr_d   <= 31'(GR_TAB[vi + 9'd1] - GR_TAB[vi]);
          le_q   <= le;
          mn_q   <= mn;
        end
        OP_FETCH2: begin
          log_lo <= 17'(LOG2_TAB[mi]);
          log_d  <= 18'(LOG2_TAB[mi + 9'd1] - LOG2_TAB[mi]);
        end
        OP_GD1B: gd1b <= {gd1_lo[17], gd1_lo} + p8[18:0];
        OP_GRB:  grb  <= gr_lo + p8[29:0];
        OP_LOG:  lval <= {le_q, 16'd0} + {5'd0, log_lo} + p8[21:0] - 22'(LOG2_ZERO);
        OP_LNF:  lnf  <= prod[51:30];
        OP_E12B: e12b <= e_sum[30:14];
        OP_E21B: e21b <= e_sum[30:14];
        OP_GD1:  gd1  <= gd1b[18] ? -$signed({1'b0, rate_sat}) : $signed({1'b0, rate_sat});
        OP_GR:   gr   <= rate_sat;
        OP_E12:  e12  <= rate_sat;
        OP_E21:  e21  <= rate_sat;
        OP_GD2:  gd2  <= rate_sat;
        OP_T:    t_q  <= prod[47:16];
        OP_K1B:  k1b  <= prod[47:16];
        OP_K2B:  k2b  <= prod[47:16];
        OP_K1:   k1   <= rate_sat;
        OP_K2:   k2   <= rate_sat;
        OP_D1:   d_q[0] <= p16[25:0];
        OP_D2:   d_q[1] <= p16[25:0];
        OP_D3:   d_q[2] <= p16[25:0];
        OP_D4:   d_q[3] <= p16[25:0];
        OP_D5:   d_q[4] <= p16[25:0];
        OP_D6:   d_q[5] <= p16[25:0];
        OP_D7:   d_q[6] <= p16[25:0];
        OP_COND: conductance <= (cond_sum > 18'd65536) ? 17'd65536 : cond_sum[16:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== tb/sv/chr2_four_state_kinetic_step_tb.sv =====
// Self-checking testbench for the four-state kinetic step, with its own conductance predictor.
`timescale 1ns / 100ps

module chr2_four_state_kinetic_step_tb;
  import cfks_pkg::*;

  localparam longint ONE_Q     = 65536;
  localparam longint RATE_CAP  = longint'(1) << 24;
  localparam longint Q30_ONE   = longint'(1) << 30;
  localparam longint RND30     = longint'(1) << 13;
  localparam longint LN2_Q30   = 744261118;
  localparam longint GD1_OFS   = 26843546;
  localparam longint GD1_AMP   = 46170898;
  localparam longint GR_SLOPE  = 22713857;
  localparam longint GR_GAIN   = 28481094;
  localparam longint E12_OFS   = 11811160;
  localparam longint E12_AMP   = 5368709;
  localparam longint E21_OFS   = 8589935;
  localparam longint E21_AMP   = 4294967;
  localparam longint GD2_Q30   = 1073742;
  localparam longint K1_GAIN   = 55935;
  localparam longint K2_GAIN   = 9175;
  localparam longint O2_WEIGHT = 107374182;
  localparam longint FLUX_OFS  = 1573;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 4'd8;

  typedef longint lut_t [0:256];

  class cond_scoreboard;
    lut_t sig_lut, gd1_lut, gr_lut, log2_lut;
    logic [31:0] scale [7];
    logic [16:0] filt_rate;
    longint c1, o1, o2, c2, act;
    logic [16:0] cond_q [$];
    int errors;

    function new();
      longint x30, e, s30, vr, v30, t30, val;
      for (int i = 0; i <= 256; i++) begin
        x30 = longint'(12000) * i * (longint'(1) << 14) - 12 * Q30_ONE;
        e = exp_q30(-2 * x30);
        s30 = (longint'(1) << 60) / (Q30_ONE + e);
        sig_lut[i] = (s30 + RND30) >>> 14;
        vr = (longint'(i) << 8) - 32768;
        v30 = vr * 4194304;
        e = exp_q30(-(v30 + 20 * Q30_ONE) / 10);
        t30 = Q30_ONE - (longint'(1) << 61) / (e + Q30_ONE);
        val = GD1_OFS + ((GD1_AMP * t30) >>> 30);
        gd1_lut[i] = (val + RND30) >>> 14;
        e = exp_q30(-((GR_SLOPE * vr) >>> 8));
        gr_lut[i] = (e * GR_GAIN + (longint'(1) << 29)) >>> 30;
        log2_lut[i] = log2_point(i);
      end
      for (int i = 0; i < 7; i++) scale[i] = SCALE_RESET;
      filt_rate = FILTER_RESET;
      c1 = ONE_Q;
      o1 = 0;
      o2 = 0;
      c2 = 0;
      act = 0;
      errors = 0;
    endfunction

    function longint exp_q30(longint y_in);
      longint y, n, r, term, sum;
      y = y_in;
      term = Q30_ONE;
      sum = Q30_ONE;
      if (y > 20 * Q30_ONE) y = 20 * Q30_ONE;
      if (y < -40 * Q30_ONE) y = -40 * Q30_ONE;
      if (y >= 0) n = y / LN2_Q30;
      else n = -((-y + LN2_Q30 - 1) / LN2_Q30);
      r = y - n * LN2_Q30;
      for (int k = 1; k <= 14; k++) begin
        term = ((term * r) >>> 30) / k;
        sum = sum + term;
      end
      if (n >= 0) return sum << n;
      return sum >>> (-n);
    endfunction

    function longint log2_point(int i);
      longint x, ip, fr;
      x = Q30_ONE + (longint'(i) << 22);
      ip = 0;
      fr = 0;
      while (x >= (longint'(1) << 31)) begin
        x = x >>> 1;
        ip++;
      end
      for (int b = 1; b <= 17; b++) begin
        x = (x * x) >>> 30;
        if (x >= (longint'(1) << 31)) begin
          x = x >>> 1;
          fr = fr | (longint'(1) << (17 - b));
        end
      end
      return (ip << 16) + ((fr + 1) >>> 1);
    endfunction

    function longint lerp(lut_t tab, longint pos);
      int idx;
      longint frac;
      idx = int'((pos >>> 8) & 255);
      frac = pos & 255;
      return tab[idx] + (((tab[idx + 1] - tab[idx]) * frac) >>> 8);
    endfunction

    function longint flux_log2(longint f);
      longint a, m, mn;
      int e;
      a = f + FLUX_OFS;
      e = 0;
      while ((a >>> (e + 1)) != 0) e++;
      m = a - (longint'(1) << e);
      if (e >= 16) mn = m >>> (e - 16);
      else mn = m << (16 - e);
      return (longint'(e) << 16) + lerp(log2_lut, mn);
    endfunction

    function longint scale_rate(longint unsigned a, logic [31:0] s);
      longint unsigned s64, p;
      s64 = s;
      if (s64 == 0 || a == 0) return 0;
      if (a > 64'hFFFF_FFFF_FFFF_FFFF / s64) return RATE_CAP;
      p = (a * s64) >> 24;
      if (p > longint'(RATE_CAP)) return RATE_CAP;
      return longint'(p);
    endfunction

    function longint signed_rate(longint a, logic [31:0] s);
      if (a >= 0) return scale_rate(a, s);
      return -scale_rate(-a, s);
    endfunction

    function longint clamp01(longint x);
      return x < 0 ? 0 : (x > ONE_Q ? ONE_Q : x);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      if (idx == REG_FILTER_RATE) filt_rate = data[16:0];
      else if (idx < REG_FILTER_RATE) scale[idx] = data;
    endfunction

    function void note_item(logic [31:0] flux_in, logic [15:0] mv_in);
      longint f, s, vpos, lnf, e12b, e21b, gd2b, fr, t, k1b, k2b;
      longint k1, k2, gd1, gd2, gr, e12, e21;
      longint d1, d2, d3, d4, d5, d6, d7, cond;
      f = flux_in;
      if (f >= 256) s = sig_lut[256];
      else s = lerp(sig_lut, f << 8);
      vpos = longint'({~mv_in[15], mv_in[14:0]});
      lnf = ((flux_log2(f) - flux_log2(0)) * LN2_Q30) >>> 30;
      e12b = (E12_OFS + ((E12_AMP * lnf) >>> 16) + RND30) >>> 14;
      e21b = (E21_OFS + ((E21_AMP * lnf) >>> 16) + RND30) >>> 14;
      gd2b = (GD2_Q30 + RND30) >>> 14;
      gd1 = signed_rate(lerp(gd1_lut, vpos), scale[REG_SCALE_GD1]);
      gr  = signed_rate(lerp(gr_lut, vpos), scale[REG_SCALE_GR]);
      e12 = signed_rate(e12b, scale[REG_SCALE_E12]);
      e21 = signed_rate(e21b, scale[REG_SCALE_E21]);
      gd2 = signed_rate(gd2b, scale[REG_SCALE_GD2]);
      fr = filt_rate > 65536 ? 65536 : longint'(filt_rate);
      act = clamp01(act + (((s - act) * fr) >>> 16));
      t = (f * act) >>> 16;
      k1b = (t * K1_GAIN) >>> 16;
      k2b = (t * K2_GAIN) >>> 16;
      k1 = scale_rate(k1b, scale[REG_SCALE_K1]);
      k2 = scale_rate(k2b, scale[REG_SCALE_K2]);
      d1 = (k1 * c1) >>> 16;
      d2 = (gd1 * o1) >>> 16;
      d3 = (gr * c2) >>> 16;
      d4 = (e21 * o2) >>> 16;
      d5 = (e12 * o1) >>> 16;
      d6 = (k2 * c2) >>> 16;
      d7 = (gd2 * o2) >>> 16;
      o1 = clamp01(o1 + d1 + d4 - d2 - d5);
      o2 = clamp01(o2 + d6 + d5 - d7 - d4);
      c2 = clamp01(c2 + d7 - d6 - d3);
      c1 = clamp01(ONE_Q - o1 - o2 - c2);
      cond = o1 + ((o2 * O2_WEIGHT + (longint'(1) << 29)) >>> 30);
      if (cond > ONE_Q) cond = ONE_Q;
      cond_q.push_back(cond[16:0]);
    endfunction

    function void check_cond(logic [16:0] got);
      logic [16:0] want;
      if (cond_q.size() == 0) begin
        $display("%0t unexpected conductance: expected none actual %0d", $time, got);
        errors++;
      end else begin
        want = cond_q.pop_front();
        if (got !== want) begin
          $display("%0t conductance mismatch: expected %0d actual %0d", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return cond_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] light_flux = '0;
  logic signed [15:0] membrane_mv = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [16:0] conductance;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  cond_scoreboard sb = new();
  bit no_gaps = 1'b0;
  int stall_left = 0;
  bit stall_mode = 1'b0;

  chr2_four_state_kinetic_step dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .light_flux(light_flux), .membrane_mv(membrane_mv),
    .out_valid(out_valid), .out_stall(out_stall), .conductance(conductance),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_item(light_flux, membrane_mv);
    if (!rst && out_valid && !out_stall) sb.check_cond(conductance);
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(9) < 2) begin
      out_stall <= 1'b0;
      stall_left <= $urandom_range(200, 50);
    end else begin
      stall_mode = ~stall_mode;
      out_stall <= stall_mode;
      stall_left <= stall_mode ? pick_gap() : $urandom_range(6);
    end
  end

  task automatic send_item(logic [31:0] f, logic [15:0] v);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0 && in_valid) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    light_flux <= f;
    membrane_mv <= v;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(6))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return SCALE_RESET;
      3: return $urandom_range(32'h0400_0000);
      4: return $urandom_range(32'h0010_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_filter();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'd65536;
      2: return {15'($urandom_range(32'h7FFF)), 17'h1FFFF};
      3: return FILTER_RESET;
      default: return {15'($urandom_range(32'h7FFF)), 17'(($urandom_range(65536)))};
    endcase
  endfunction

  function automatic logic [31:0] pick_flux(int cls);
    case (cls)
      0: return 32'd0;
      1: return $urandom_range(255);
      2: return $urandom_range(32'h000F_FFFF, 256);
      3: return $urandom_range(32'h00FF_FFFF);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] pick_mv();
    if ($urandom_range(3) == 0) return 16'($urandom());
    return 16'($signed($urandom_range(60 * 256 + 100 * 256)) - 100 * 256);
  endfunction

  task automatic config_all();
    write_reg(REG_SCALE_K1, pick_scale());
    write_reg(REG_SCALE_K2, pick_scale());
    write_reg(REG_SCALE_GD1, pick_scale());
    write_reg(REG_SCALE_GD2, pick_scale());
    write_reg(REG_SCALE_GR, pick_scale());
    write_reg(REG_SCALE_E12, pick_scale());
    write_reg(REG_SCALE_E21, pick_scale());
    write_reg(REG_FILTER_RATE, pick_filter());
    write_reg(4'($urandom_range(15, REG_FIRST_UNUSED)), $urandom());
  endtask

  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int run_left, cls;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(32'd0, 16'sh8000);
    send_item(32'd255, 16'sh7FFF);
    send_item(32'd256, 16'sd0);
    send_item(32'hFFFF_FFFF, -16'sd5120);
    for (int i = 0; i < 6; i++) send_item(32'h0010_0000, 16'sh7FFF);
    send_item(32'hFFFF_FFFF, 16'sh8000);
    drain();

    write_reg(REG_FILTER_RATE, 32'd65536);
    write_reg(REG_SCALE_K1, 32'hFFFF_FFFF);
    write_reg(REG_SCALE_K2, 32'hFFFF_FFFF);
    write_reg(REG_SCALE_GD1, 32'hFFFF_FFFF);
    write_reg(REG_SCALE_GD2, 32'hFFFF_FFFF);
    write_reg(REG_SCALE_GR, 32'hFFFF_FFFF);
    write_reg(REG_SCALE_E12, 32'hFFFF_FFFF);
    write_reg(REG_SCALE_E21, 32'hFFFF_FFFF);
    write_reg(REG_FIRST_UNUSED, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, 16'sh7FFF);
    send_item(32'd128, 16'sh8000);
    send_item(32'hFFFF_FFFF, 16'sd0);
    drain();

    write_reg(REG_FILTER_RATE, 32'hFFFF_FFFF);
    write_reg(REG_SCALE_K1, 32'd0);
    write_reg(REG_SCALE_K2, 32'd0);
    write_reg(REG_SCALE_GD1, 32'd0);
    write_reg(REG_SCALE_GD2, 32'd0);
    write_reg(REG_SCALE_GR, 32'd0);
    write_reg(REG_SCALE_E12, 32'd0);
    write_reg(REG_SCALE_E21, 32'd0);
    send_item(32'hFFFF_FFFF, 16'sh7FFF);
    send_item(32'd1, 16'sh8001);
    drain();
    write_reg(REG_FILTER_RATE, 32'd0);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        write_reg(REG_SCALE_K1, SCALE_RESET);
        write_reg(REG_SCALE_K2, SCALE_RESET);
        write_reg(REG_SCALE_GD1, SCALE_RESET);
        write_reg(REG_SCALE_GD2, SCALE_RESET);
        write_reg(REG_SCALE_GR, SCALE_RESET);
        write_reg(REG_SCALE_E12, SCALE_RESET);
        write_reg(REG_SCALE_E21, SCALE_RESET);
        write_reg(REG_FILTER_RATE, FILTER_RESET);
      end else begin
        config_all();
      end
      run_left = 0;
      cls = 0;
      for (int n = 0; n < 105; n++) begin
        if (run_left == 0) begin
          run_left = $urandom_range(40, 5);
          cls = $urandom_range(4);
          no_gaps = ($urandom_range(3) == 0);
        end
        run_left--;
        if (ph == 3 && n == 50) drain();
        send_item(pick_flux(cls), pick_mv());
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
